// File: rtl/lemf_pkg.sv
// Shared types, constants and pixel functions of the Laplacian edge mask filter.
// Used by every module of the block; depends on nothing else.
package lemf_pkg;

	localparam int PIX_W     = 24;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int LUMA_W    = 6;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

	typedef struct packed {
		logic is_pixel;
		logic emit;
		logic interior;
		logic last;
		logic use_hold;
	} lemf_item_t;

	function automatic logic [LUMA_W-1:0] lemf_luma(input logic [PIX_W-1:0] px);
		logic [9:0] total;
		total = 10'(px[23:16]) + 10'(px[15:8]) + 10'(px[7:0]);
		return total[9:4];
	endfunction

	// The edge test keeps bits 7 to 5 of the 8-bit difference.
	function automatic logic lemf_is_edge(input logic [LUMA_W-1:0] center,
			input logic [7:0] cross_sum);
		logic [7:0] diff;
		diff = {2'b00, center} - {2'b00, cross_sum[7:2]};
		return |diff[7:5];
	endfunction

endpackage

// File: rtl/laplacian_edge_mask_filter.sv
// Top level of the four-neighbor Laplacian edge mask filter on a raster RGB stream.
// Instantiates lemf_ctrl, two lemf_row_mem row stores and lemf_pipe; uses lemf_pkg.
//
// The filter takes one transaction per clock, pixel or flush, while in_ready is high, and
// gives at most one result per transaction; a result is registered: the transaction that
// causes it passes the s1 stage register and then the output register, and for a pixel is
// the one arriving frame_width+1 pixels later. Throughput is set by the two row store RAMs, each with one
// read and one write port: every pixel reads and writes both at its column, so they are
// fully used at one pixel per cycle, and a stalled output holds at most one more
// transaction inside. The row stores hold no reset and are not cleared, so the block
// accepts transactions right after reset. Writing frame_width or frame_height restarts
// the frame and drops pending pixels; write only while the block is idle.
module laplacian_edge_mask_filter #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lemf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lemf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [lemf_pkg::PIX_W-1:0]      pixel_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lemf_pkg::PIX_W-1:0]      pixel_out,
	output logic                            edge_found,
	output logic                            frame_last
);
	import lemf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic             in_fire;
	lemf_item_t       item;
	logic [AW-1:0]    col;
	logic [AW-1:0]    rd_addr;
	logic [PIX_W-1:0] recent_rd;
	logic [PIX_W-1:0] older_rd;
	logic             older_we;
	logic [AW-1:0]    older_waddr;
	logic [PIX_W-1:0] older_wdata;

	assign in_fire = in_valid && in_ready;

	lemf_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_fire  (in_fire),
		.kind     (kind),
		.item     (item),
		.col      (col),
		.rd_addr  (rd_addr)
	);

	lemf_row_mem #(
		.DEPTH(MAX_WIDTH)
	) u_recent (
		.clk  (clk),
		.we   (in_fire && item.is_pixel),
		.waddr(col),
		.wdata(pixel_in),
		.re   (in_fire),
		.raddr(rd_addr),
		.rdata(recent_rd)
	);

	lemf_row_mem #(
		.DEPTH(MAX_WIDTH)
	) u_older (
		.clk  (clk),
		.we   (older_we),
		.waddr(older_waddr),
		.wdata(older_wdata),
		.re   (in_fire && item.is_pixel),
		.raddr(col),
		.rdata(older_rd)
	);

	lemf_pipe #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.item       (item),
		.pixel_in   (pixel_in),
		.col        (col),
		.s1_ready   (in_ready),
		.recent_rd  (recent_rd),
		.older_rd   (older_rd),
		.older_we   (older_we),
		.older_waddr(older_waddr),
		.older_wdata(older_wdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.edge_found (edge_found),
		.frame_last (frame_last)
	);

endmodule

// File: rtl/lemf_row_mem.sv
// One row store: a single-port-write, single-port-read synchronous RAM of pixels.
// Read data is registered and held while the read enable is low; uses lemf_pkg.
module lemf_row_mem #(
	parameter int DEPTH = 2048
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [lemf_pkg::PIX_W-1:0]  wdata,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [lemf_pkg::PIX_W-1:0]  rdata
);
	import lemf_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/lemf_ctrl.sv
// Front-end control: configuration registers, input column, pending count and output
// position. Decides per transaction whether a result leaves; uses lemf_pkg.
module lemf_ctrl #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lemf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lemf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_fire,
	input  logic                            kind,
	output lemf_pkg::lemf_item_t            item,
	output logic [$clog2(MAX_WIDTH)-1:0]    col,
	output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr
);
	import lemf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int CW = (WW > CFG_W) ? WW : CFG_W;

	function automatic logic [WW-1:0] eff_width(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ve;
		ve = CW'(v);
		if (v == '0) begin
			return WW'(1);
		end
		if (ve > CW'(MAX_WIDTH)) begin
			return WW'(MAX_WIDTH);
		end
		return WW'(ve);
	endfunction

	logic [WW-1:0]    w_q;
	logic [CFG_W-1:0] h_q;
	logic [AW-1:0]    col_q;
	logic [PW-1:0]    pend_q;
	logic [AW-1:0]    ocol_q;
	logic [CFG_W-1:0] orow_q;

	logic [WW-1:0]    wm1;
	logic [CFG_W-1:0] hm1;
	logic             is_pixel;
	logic             has_out;
	logic             col_end;
	logic             ocol_end;
	logic [PW-1:0]    flush_pos;

	assign wm1      = w_q - WW'(1);
	assign hm1      = h_q - CFG_W'(1);
	assign is_pixel = (kind == KIND_PIXEL);
	assign col_end  = (col_q == AW'(wm1));
	assign ocol_end = (ocol_q == AW'(wm1));

	always_comb begin
		if (is_pixel) begin
			has_out = (pend_q == PW'(w_q) + PW'(1));
		end else begin
			has_out = (pend_q != '0);
		end
		if (PW'(col_q) >= pend_q) begin
			flush_pos = PW'(col_q) - pend_q;
		end else begin
			flush_pos = PW'(col_q) + PW'(w_q) - pend_q;
		end
		item.is_pixel = is_pixel;
		item.emit     = has_out;
		item.interior = is_pixel && (orow_q != '0) && (orow_q != hm1) &&
			(ocol_q != '0) && !ocol_end;
		item.last     = ocol_end && (orow_q == hm1);
		item.use_hold = !is_pixel && (pend_q > PW'(w_q));
	end

	assign col     = col_q;
	assign rd_addr = is_pixel ? col_q : AW'(flush_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= eff_width(RESET_WIDTH);
			h_q    <= RESET_HEIGHT;
			col_q  <= '0;
			pend_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					w_q <= eff_width(cfg_data);
				end
				REG_FRAME_HEIGHT: begin
					h_q <= (cfg_data == '0) ? CFG_W'(1) : cfg_data;
				end
				default: begin
					h_q <= h_q;
				end
			endcase
			col_q  <= '0;
			pend_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (in_fire) begin
			if (is_pixel) begin
				col_q <= col_end ? '0 : col_q + AW'(1);
				if (!has_out) begin
					pend_q <= pend_q + PW'(1);
				end
			end else if (has_out) begin
				pend_q <= pend_q - PW'(1);
			end
			if (has_out) begin
				if (ocol_end) begin
					ocol_q <= '0;
					orow_q <= (orow_q == hm1) ? '0 : orow_q + CFG_W'(1);
				end else begin
					ocol_q <= ocol_q + AW'(1);
				end
			end
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(w_q) + PW'(1))
		else $error("pending count exceeds one row plus one pixel");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(PW'(col_q) < PW'(w_q)) && (PW'(ocol_q) < PW'(w_q)))
		else $error("column position outside the frame width");

endmodule

// File: rtl/lemf_pipe.sv
// Read-modify-write stage and output register: combines row store reads with the
// pixel history, runs the edge test and writes the older row store; uses lemf_pkg.
module lemf_pipe #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_fire,
	input  lemf_pkg::lemf_item_t            item,
	input  logic [lemf_pkg::PIX_W-1:0]      pixel_in,
	input  logic [$clog2(MAX_WIDTH)-1:0]    col,
	output logic                            s1_ready,
	input  logic [lemf_pkg::PIX_W-1:0]      recent_rd,
	input  logic [lemf_pkg::PIX_W-1:0]      older_rd,
	output logic                            older_we,
	output logic [$clog2(MAX_WIDTH)-1:0]    older_waddr,
	output logic [lemf_pkg::PIX_W-1:0]      older_wdata,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lemf_pkg::PIX_W-1:0]      pixel_out,
	output logic                            edge_found,
	output logic                            frame_last
);
	import lemf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic             s1_valid;
	lemf_item_t       item_s1;
	logic [PIX_W-1:0] px_s1;
	logic [AW-1:0]    addr_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_data_s1;

	logic [PIX_W-1:0]  center_q;
	logic [LUMA_W-1:0] lc_q;
	logic [LUMA_W-1:0] lh2_q;
	logic [LUMA_W-1:0] lprev_q;
	logic [LUMA_W-1:0] labove_q;

	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic             edge_q;
	logic             last_q;

	logic             s1_fire;
	logic [PIX_W-1:0] older_eff;
	logic [7:0]       cross_sum;
	logic             edge_det;
	logic [PIX_W-1:0] result_px;

	assign s1_fire  = s1_valid && (!item_s1.emit || !out_valid_q || out_ready);
	assign s1_ready = !s1_valid || s1_fire;

	assign older_eff = fwd_s1 ? fwd_data_s1 : older_rd;
	assign cross_sum = 8'(labove_q) + 8'(lprev_q) + 8'(lh2_q) + 8'(lemf_luma(recent_rd));
	assign edge_det  = item_s1.interior && lemf_is_edge(lc_q, cross_sum);

	always_comb begin
		if (item_s1.is_pixel || item_s1.use_hold) begin
			result_px = center_q;
		end else begin
			result_px = recent_rd;
		end
	end

	assign older_we    = s1_fire && item_s1.is_pixel;
	assign older_waddr = addr_s1;
	assign older_wdata = recent_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_fire) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1     <= item;
			px_s1       <= pixel_in;
			addr_s1     <= col;
			fwd_s1      <= older_we && (addr_s1 == col) && item.is_pixel;
			fwd_data_s1 <= recent_rd;
		end
	end

	// The history registers stand in for the reads one and two columns back.
	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.is_pixel) begin
			center_q <= recent_rd;
			lc_q     <= lemf_luma(recent_rd);
			lh2_q    <= lc_q;
			lprev_q  <= lemf_luma(px_s1);
			labove_q <= lemf_luma(older_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && item_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.emit) begin
			pixel_out_q <= edge_det ? '0 : result_px;
			edge_q      <= edge_det;
			last_q      <= item_s1.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign edge_found = edge_q;
	assign frame_last = last_q;

	a_edge_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && edge_q |-> pixel_out_q == '0)
		else $error("pixel flagged as edge is not black");

	a_flush_border: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !item_s1.is_pixel |-> !item_s1.interior)
		else $error("flush transaction marked as interior");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_fire |=> s1_valid && $stable(px_s1) && $stable(addr_s1))
		else $error("stalled stage lost or changed its transaction");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for laplacian_edge_mask_filter: raster frames of RGB pixels and
// flush transactions under random idling, checked against a predictor of the edge mask.
// Depends on lemf_pkg and the laplacian_edge_mask_filter RTL.
module tb;
	import lemf_pkg::*;

	localparam int MAX_W         = 2048;
	localparam int SETTLE        = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PIXELS = 1600;
	localparam int MAX_REPORTS   = 200;

	typedef enum {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;
	typedef enum {PX_NOISE, PX_FLAT, PX_DOTS, PX_TWO_LEVEL, PX_EXTREME} scene_t;
	typedef enum {WR_WIDTH_FIRST, WR_HEIGHT_FIRST, WR_WIDTH_ONLY, WR_HEIGHT_ONLY} geo_order_t;

	typedef struct packed {
		bit [PIX_W-1:0] px;
		bit             cleared;
		bit             last;
	} mask_result_t;

	class edge_mask_scoreboard;
		bit [PIX_W-1:0] recent_row [MAX_W];
		bit [PIX_W-1:0] older_row [MAX_W];
		bit [CFG_W-1:0] width_reg;
		bit [CFG_W-1:0] height_reg;
		int unsigned    col_pos, row_pos, queued, out_col, out_row;
		bit [PIX_W-1:0] hold_px;
		mask_result_t   expected_q[$];
		int             errors, pixels_taken, flushes_taken;
		int             results_checked, edges_cleared, frame_ends;

		function new();
			width_reg  = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			restart();
		endfunction

		function void restart();
			col_pos = 0;
			row_pos = 0;
			queued  = 0;
			hold_px = '0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int unsigned cols();
			int unsigned v;
			v = width_reg;
			if (v == 0) v = 1;
			if (v > MAX_W) v = MAX_W;
			return v;
		endfunction

		function int unsigned rows();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_FRAME_WIDTH) width_reg = val;
			else height_reg = val;
			restart();
		endfunction

		function int unsigned brightness(bit [PIX_W-1:0] p);
			return (32'(p[23:16]) + 32'(p[15:8]) + 32'(p[7:0])) >> 4;
		endfunction

		function void queue_result(bit [PIX_W-1:0] px, bit cleared, int unsigned w,
				int unsigned h);
			mask_result_t r;
			r.px      = cleared ? '0 : px;
			r.cleared = cleared;
			r.last    = (out_col + 1 >= w) && (out_row + 1 >= h);
			expected_q.push_back(r);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
				if (out_row >= h) out_row = 0;
			end
		endfunction

		function void take_input(logic k, logic [PIX_W-1:0] px_in);
			int unsigned    w, h, c, cm1, cm2, nbr_sum;
			bit [PIX_W-1:0] center, displaced;
			bit [7:0]       diff;
			bit             cleared;
			w = cols();
			h = rows();
			c = col_pos;
			if (c >= w) c = 0;
			cm1 = (c + w - 1) % w;
			cm2 = (c + 2 * w - 2) % w;
			if (k == KIND_FLUSH) begin
				flushes_taken++;
				if (queued == 0) return;
				if (queued > w) queue_result(older_row[cm1], 1'b0, w, h);
				else queue_result(recent_row[(c + w - queued) % w], 1'b0, w, h);
				queued--;
				return;
			end
			pixels_taken++;
			if (queued >= w + 1) begin
				center  = older_row[cm1];
				cleared = 1'b0;
				if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
					nbr_sum = brightness(hold_px) + brightness(recent_row[cm1]) +
						brightness(older_row[cm2]) + brightness(recent_row[c]);
					diff = 8'(brightness(center) - (nbr_sum >> 2));
					cleared = (((diff & 8'hFE) >> 1) & 8'hF0) != 0;
				end
				queue_result(center, cleared, w, h);
			end else begin
				queued++;
			end
			displaced     = older_row[c];
			older_row[c]  = recent_row[c];
			recent_row[c] = px_in;
			hold_px       = displaced;
			c++;
			if (c >= w) begin
				c = 0;
				row_pos++;
				if (row_pos >= h) row_pos = 0;
			end
			col_pos = c;
		endfunction

		function void mismatch(string what, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
		endfunction

		function void check_output(logic [PIX_W-1:0] px, logic ef, logic fl);
			mask_result_t e;
			results_checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: result with none expected, expected nothing, actual %h",
						$time, px);
				return;
			end
			e = expected_q.pop_front();
			if (px !== e.px) mismatch("pixel_out", e.px, px);
			if (ef !== e.cleared) mismatch("edge_found", PIX_W'(e.cleared), PIX_W'(ef));
			if (fl !== e.last) mismatch("frame_last", PIX_W'(e.last), PIX_W'(fl));
			if (e.cleared) edges_cleared++;
			if (e.last) frame_ends++;
		endfunction
	endclass

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic                 kind       = KIND_PIXEL;
	logic [PIX_W-1:0]     pixel_in   = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [PIX_W-1:0]     pixel_out;
	logic                 edge_found;
	logic                 frame_last;

	edge_mask_scoreboard sb = new();
	int burst_left  = 0;
	int pixels_sent = 0;
	int phases      = 0;
	bit hold_req    = 1'b0;
	bit hold_used   = 1'b0;

	laplacian_edge_mask_filter #(.MAX_WIDTH(MAX_W)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.edge_found (edge_found),
		.frame_last (frame_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.take_input(kind, pixel_in);
			if (out_valid && out_ready) sb.check_output(pixel_out, edge_found, frame_last);
		end
	end

	initial begin
		rx_mode_t rx_mode;
		int       rx_left;
		int       rx_tick;
		rx_mode = RX_STEADY;
		rx_left = 50;
		rx_tick = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				rx_tick++;
				case (rx_mode)
					RX_STEADY:  out_ready <= 1'b1;
					RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: out_ready <= (rx_tick % 5) < 3;
					default:    out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				rx_left--;
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(10, 150);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(input logic k, input logic [PIX_W-1:0] px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		kind     <= k;
		pixel_in <= px;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (k == KIND_PIXEL) pixels_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input geo_order_t order);
		case (order)
			WR_WIDTH_FIRST: begin
				write_cfg(REG_FRAME_WIDTH, w);
				write_cfg(REG_FRAME_HEIGHT, h);
			end
			WR_HEIGHT_FIRST: begin
				write_cfg(REG_FRAME_HEIGHT, h);
				write_cfg(REG_FRAME_WIDTH, w);
			end
			WR_WIDTH_ONLY:  write_cfg(REG_FRAME_WIDTH, w);
			default:        write_cfg(REG_FRAME_HEIGHT, h);
		endcase
		cfg_wr_en <= 1'b0;
		phases++;
	endtask

	function automatic logic [PIX_W-1:0] make_pixel(input scene_t scene, input int base);
		logic [7:0] hi;
		hi = 8'(255 - base);
		case (scene)
			PX_NOISE: return 24'($urandom);
			PX_FLAT:  return {8'(base + $urandom_range(0, 7)), 8'(base + $urandom_range(0, 7)),
				8'(base + $urandom_range(0, 7))};
			PX_DOTS:  return ($urandom_range(0, 7) == 0) ? 24'hFFFFFF ^ 24'($urandom_range(0, 255))
				: {8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)), 8'($urandom_range(0, 31))};
			PX_TWO_LEVEL: return $urandom_range(0, 1) ? {3{8'(base)}} : {3{hi}};
			default:  return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
		endcase
	endfunction

	task automatic send_frame(input int stop_at, input int hold_at);
		scene_t scene;
		int     total, base;
		scene = scene_t'($urandom_range(0, 4));
		base  = $urandom_range(0, 247);
		total = sb.cols() * sb.rows();
		for (int i = 0; i < total && i < stop_at; i++) begin
			if ($urandom_range(0, 39) == 0) send_item(KIND_FLUSH, 24'($urandom));
			if (!hold_used && pixels_sent >= hold_at) begin
				hold_req  = 1'b1;
				hold_used = 1'b1;
			end
			send_item(KIND_PIXEL, make_pixel(scene, base));
		end
	endtask

	initial begin
		logic [PIX_W-1:0] grid [9];
		logic [CFG_W-1:0] w, h;
		int               target, frames, total, stop_at, pick;
		grid = '{24'h000000, 24'h0F0F0F, 24'hFFFFFF,
			24'h000000, 24'hFFFFFF, 24'h000000,
			24'h808080, 24'h000000, 24'hFFFFFF};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(KIND_FLUSH, 24'h000000);
		send_item(KIND_PIXEL, 24'h000000);
		send_item(KIND_PIXEL, 24'hFFFFFF);
		wait_idle();

		set_geometry(12'd3, 12'd3, WR_WIDTH_FIRST);
		foreach (grid[i]) send_item(KIND_PIXEL, grid[i]);
		repeat (5) send_item(KIND_FLUSH, 24'($urandom));
		wait_idle();

		set_geometry(12'd1, 12'd1, WR_HEIGHT_FIRST);
		send_item(KIND_PIXEL, 24'hFFFFFF);
		send_item(KIND_PIXEL, 24'h000000);
		send_item(KIND_PIXEL, 24'h5A5A5A);
		repeat (3) send_item(KIND_FLUSH, 24'hFFFFFF);
		wait_idle();

		set_geometry(12'd0, 12'd0, WR_HEIGHT_FIRST);
		repeat (3) send_item(KIND_PIXEL, 24'($urandom));
		repeat (2) send_item(KIND_FLUSH, 24'($urandom));
		wait_idle();

		set_geometry(12'd2048, 12'hFFF, WR_WIDTH_FIRST);
		for (int i = 0; i < 24; i++) send_item(KIND_PIXEL, 24'($urandom));
		repeat (26) send_item(KIND_FLUSH, 24'($urandom));
		wait_idle();

		set_geometry(12'hFFF, 12'd3, WR_WIDTH_FIRST);
		repeat (4) send_item(KIND_PIXEL, 24'($urandom));
		wait_idle();

		target = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) w = CFG_W'($urandom_range(0, 2));
			else if (pick < 7) w = CFG_W'($urandom_range(3, 12));
			else w = CFG_W'($urandom_range(13, 40));
			h = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 1)) :
				CFG_W'($urandom_range(2, 8));
			set_geometry(w, h, geo_order_t'($urandom_range(0, 3)));
			frames = $urandom_range(1, 3);
			total  = sb.cols() * sb.rows();
			for (int f = 0; f < frames; f++) begin
				stop_at = (f == frames - 1 && $urandom_range(0, 5) == 0) ?
					$urandom_range(1, total) : total;
				send_frame(stop_at, target - 1200);
			end
			if ($urandom_range(0, 5) < 4)
				repeat (sb.cols() + 1 + $urandom_range(0, 2))
					send_item(KIND_FLUSH, 24'($urandom));
			wait_idle();
		end

		$display("Run covered %0d pixels and %0d flush transactions over %0d frame setups.",
			sb.pixels_taken, sb.flushes_taken, phases);
		$display("Checked %0d results: %0d cleared as edges, %0d frame ends, %0d errors.",
			sb.results_checked, sb.edges_cleared, sb.frame_ends, sb.errors);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
